// ----- hdl/cid_pkg.sv -----
// Shared types and constants for the compact index decoder.
package cid_pkg;

	localparam int unsigned MaxBytes = 5;
	localparam int unsigned CountW   = 3;
	localparam int unsigned MagW     = 31;
	localparam int unsigned ValueW   = 32;

	localparam logic [CountW-1:0] CountSat = 3'd6;
	localparam logic [CountW-1:0] CountMax = 3'd5;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_TOO_LONG = 3'd1,
		ST_MID      = 3'd2,
		ST_OVERFLOW = 3'd3,
		ST_TRAILING = 3'd4
	} status_t;

	typedef struct packed {
		status_t            status;
		logic [ValueW-1:0]  value;
		logic [CountW-1:0]  byte_count;
	} result_t;

endpackage

// ----- hdl/compact_index_decoder_unit.sv -----
// Top level of the compact index decoder: byte stream in, one result per span out.
//
//  channel  | dir | payload                                | end marker
//  s_axis   | in  | tdata[7:0] data_byte                   | tlast = span_end
//  m_axis   | out | tuser status; tdata value, byte_count  | none
//
// One byte per cycle while s_tready is high; a span's result is registered into the
// output register, or the skid entry on a stall. Decode state sits in one register
// stage ahead of it; without a stall, throughput is set by the accumulator update alone.
// Reset clears the accumulator and empties the output stage.
// A stalled output fills a one-entry skid, after which s_tready drops.
module compact_index_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // span_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] value, [34:32] byte_count, rest zero
	output logic [2:0]  m_tuser    // [2:0] status
);
	import cid_pkg::*;

	logic    accept;
	logic    res_valid;
	result_t res;
	result_t out_res;

	assign accept = s_tvalid && s_tready;

	cid_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (s_tdata),
		.span_end  (s_tlast),
		.res_valid (res_valid),
		.res       (res)
	);

	cid_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.can_push  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_res)
	);

	assign m_tuser = out_res.status;
	assign m_tdata = {5'd0, out_res.byte_count, out_res.value};

endmodule

// ----- hdl/cid_decode.sv -----
// Per-byte decode: accumulator state and result formation at the end of a span.
module cid_decode (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [7:0]         data_byte,
	input  logic               span_end,
	output logic               res_valid,
	output cid_pkg::result_t   res
);
	import cid_pkg::*;

	logic [MagW-1:0]   mag_q;
	logic              sign_q;
	logic [CountW-1:0] seen_q;
	logic              cont_q;
	status_t           err_q;

	logic [MagW-1:0]   mag_d;
	logic              sign_d;
	logic [CountW-1:0] seen_d;
	logic              cont_d;
	status_t           err_d;
	logic [6:0]        payload;
	logic [MagW-1:0]   placed;
	logic              ovf;
	status_t           status;
	logic [ValueW-1:0] value;

	assign payload = data_byte[6:0];

	// Place the 7 payload bits above those already taken; the fifth byte places only its low 4 and flags overflow
	always_comb begin
		placed = '0;
		ovf    = 1'b0;
		case (seen_q)
			3'd1: placed = {{(MagW-13){1'b0}}, payload, 6'd0};
			3'd2: placed = {{(MagW-20){1'b0}}, payload, 13'd0};
			3'd3: placed = {{(MagW-27){1'b0}}, payload, 20'd0};
			3'd4: begin
				ovf    = payload[6:4] != 3'd0;
				placed = {payload[3:0], 27'd0};
			end
			default: placed = '0;
		endcase
	end

	always_comb begin
		mag_d  = mag_q;
		sign_d = sign_q;
		cont_d = cont_q;
		err_d  = err_q;
		if (seen_q == '0) begin
			sign_d = data_byte[7];
			mag_d  = {{(MagW-6){1'b0}}, data_byte[5:0]};
			cont_d = data_byte[6];
		end else if (seen_q < CountMax) begin
			if (cont_q) begin
				if (ovf) begin
					if (err_q == ST_OK)
						err_d = ST_OVERFLOW;
				end else begin
					mag_d = mag_q | placed;
				end
				cont_d = data_byte[7];
			end else if (err_q == ST_OK) begin
				err_d = ST_TRAILING;
			end
		end
		seen_d = (seen_q >= CountMax) ? CountSat : seen_q + 3'd1;
	end

	always_comb begin
		if (seen_d > CountMax)
			status = ST_TOO_LONG;
		else if (cont_d)
			status = ST_MID;
		else
			status = err_d;
	end

	always_comb begin
		value = '0;
		if (status == ST_OK)
			value = sign_d ? (ValueW'(0) - {1'b0, mag_d}) : {1'b0, mag_d};
	end

	assign res_valid = accept && span_end;
	assign res       = {status, value, seen_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mag_q  <= '0;
			sign_q <= 1'b0;
			seen_q <= '0;
			cont_q <= 1'b0;
			err_q  <= ST_OK;
		end else if (accept) begin
			if (span_end) begin
				mag_q  <= '0;
				sign_q <= 1'b0;
				seen_q <= '0;
				cont_q <= 1'b0;
				err_q  <= ST_OK;
			end else begin
				mag_q  <= mag_d;
				sign_q <= sign_d;
				seen_q <= seen_d;
				cont_q <= cont_d;
				err_q  <= err_d;
			end
		end
	end

endmodule

// ----- hdl/cid_out_buf.sv -----
// Output register with a skid entry so input is not tied to the output ready.
module cid_out_buf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  cid_pkg::result_t   push_data,
	output logic               can_push,
	output logic               out_valid,
	input  logic               out_ready,
	output cid_pkg::result_t   out_data
);
	import cid_pkg::*;

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_q;
	result_t skid_q;
	logic    drain;

	assign drain     = !out_valid_q || out_ready;
	assign can_push  = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (drain) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (drain) begin
			if (skid_valid_q)
				out_q <= skid_q;
			else if (push)
				out_q <= push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule
